@@ hdl/rc_channel_frame_decoder_core_defines.svh @@
// Assertion macros used by the decoder emitter module.
`ifndef RC_CHANNEL_FRAME_DECODER_CORE_DEFINES_SVH
`define RC_CHANNEL_FRAME_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RCFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcfd assertion failed");

// Next-cycle implication, checked outside reset.
`define RCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcfd assertion failed");

`endif

@@ hdl/rcfd_pkg.sv @@
`default_nettype none

package rcfd_pkg;

  localparam int FRAME_BYTES   = 25;
  localparam int CHANNEL_COUNT = 16;
  localparam int STORE_DEPTH   = FRAME_BYTES - 2;
  localparam int DATA_BYTES    = STORE_DEPTH - 1;
  localparam int CH_BITS       = 11;
  localparam int DATA_W        = DATA_BYTES * 8;
  localparam int CNT_W         = $clog2(FRAME_BYTES);
  localparam int IDX_W         = $clog2(CHANNEL_COUNT);
  localparam int FLAG_W        = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END    = 2'd1;

  localparam logic [7:0] HEADER_RESET = 8'h0F;
  localparam logic [7:0] END_RESET    = 8'h00;

  // Completed frame handed from the framer to the emitter
  typedef struct packed {
    logic              valid;
    logic              reject;
    logic [FLAG_W-1:0] flags;
    logic [DATA_W-1:0] data;
  } frame_t;

endpackage

`default_nettype wire

@@ hdl/rcfd_framer.sv @@
`default_nettype none

module rcfd_framer (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_take,
  input  wire logic [7:0]    rx_byte,
  input  wire logic [7:0]    header_value,
  input  wire logic [7:0]    end_value,
  output logic               at_end,
  output rcfd_pkg::frame_t   frame
);

  localparam logic [rcfd_pkg::CNT_W-1:0] END_POS =
    rcfd_pkg::CNT_W'(rcfd_pkg::FRAME_BYTES - 1);

  logic                         collecting_r, collecting_nxt;
  logic [rcfd_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [7:0]                   store_r [rcfd_pkg::STORE_DEPTH];
  logic [rcfd_pkg::CNT_W-1:0]   wr_idx;
  logic                         wr_en;
  logic [rcfd_pkg::DATA_W-1:0]  data_bits;

  assign at_end = collecting_r && (count_r == END_POS);
  assign wr_idx = count_r - rcfd_pkg::CNT_W'(1);
  assign wr_en  = byte_take && collecting_r && (count_r != END_POS);

  // Advance the hunt / collect sequence
  always_comb begin
    collecting_nxt = collecting_r;
    count_nxt      = count_r;
    if (byte_take) begin
      if (!collecting_r) begin
        if (rx_byte == header_value) begin
          collecting_nxt = 1'b1;
          count_nxt      = rcfd_pkg::CNT_W'(1);
        end
      end else if (count_r == END_POS) begin
        collecting_nxt = 1'b0;
        count_nxt      = '0;
      end else begin
        count_nxt = count_r + rcfd_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      count_r      <= '0;
    end else begin
      collecting_r <= collecting_nxt;
      count_r      <= count_nxt;
    end
  end

  // Hold payload bytes 1..23
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_idx] <= rx_byte;
    end
  end

  // Gather channel bytes LSB-first
  always_comb begin
    for (int i = 0; i < rcfd_pkg::DATA_BYTES; i++) begin
      data_bits[i*8 +: 8] = store_r[i];
    end
  end

  // Hand over the frame on the end byte
  always_comb begin
    frame.valid  = byte_take && at_end;
    frame.reject = rx_byte != end_value;
    frame.flags  = store_r[rcfd_pkg::STORE_DEPTH-1][rcfd_pkg::FLAG_W-1:0];
    frame.data   = data_bits;
  end

endmodule

`default_nettype wire

@@ hdl/rcfd_emitter.sv @@
`default_nettype none
`include "rc_channel_frame_decoder_core_defines.svh"

module rcfd_emitter (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rcfd_pkg::frame_t            frame,
  output logic                             busy,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_status,
  output logic [3:0]                       out_channel_index,
  output logic [10:0]                      out_channel_value,
  output logic                             out_digital_one,
  output logic                             out_digital_two,
  output logic                             out_lost_flag,
  output logic                             out_safe_mode_flag,
  output logic                             out_last
);

  localparam logic [rcfd_pkg::IDX_W-1:0] LAST_IDX =
    rcfd_pkg::IDX_W'(rcfd_pkg::CHANNEL_COUNT - 1);

  logic                          busy_r, busy_nxt;
  logic                          reject_r, reject_nxt;
  logic [rcfd_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [rcfd_pkg::FLAG_W-1:0]   flags_r, flags_nxt;
  logic [rcfd_pkg::DATA_W-1:0]   data_r, data_nxt;
  logic                          xfer;
  logic                          last_res;

  assign busy     = busy_r;
  assign xfer     = busy_r && !out_stall;
  assign last_res = reject_r || (idx_r == LAST_IDX);

  // Load a frame, or shift to the next channel after each transfer
  always_comb begin
    busy_nxt   = busy_r;
    reject_nxt = reject_r;
    idx_nxt    = idx_r;
    flags_nxt  = flags_r;
    data_nxt   = data_r;
    if (frame.valid) begin
      busy_nxt   = 1'b1;
      reject_nxt = frame.reject;
      idx_nxt    = '0;
      flags_nxt  = frame.flags;
      data_nxt   = frame.data;
    end else if (xfer) begin
      if (last_res) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt  = idx_r + rcfd_pkg::IDX_W'(1);
        data_nxt = data_r >> rcfd_pkg::CH_BITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      reject_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      busy_r   <= busy_nxt;
      reject_r <= reject_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flags_r <= flags_nxt;
    data_r  <= data_nxt;
  end

  // Drive the result; a rejection carries only status and last
  assign out_valid          = busy_r;
  assign out_status         = reject_r;
  assign out_last           = last_res;
  assign out_channel_index  = reject_r ? '0 : idx_r;
  assign out_channel_value  = reject_r ? '0 : data_r[rcfd_pkg::CH_BITS-1:0];
  assign out_digital_one    = !reject_r && flags_r[0];
  assign out_digital_two    = !reject_r && flags_r[1];
  assign out_lost_flag      = !reject_r && flags_r[2];
  assign out_safe_mode_flag = !reject_r && flags_r[3];

  `RCFD_ASSERT_NOW(a_load_when_idle, clk, rst_n, frame.valid, !busy_r)
  `RCFD_ASSERT_NOW(a_reject_single, clk, rst_n, busy_r && reject_r, idx_r == '0)
  `RCFD_ASSERT_NEXT(a_idle_after_last, clk, rst_n, xfer && last_res && !frame.valid, !busy_r)
  `RCFD_ASSERT_NEXT(a_index_steps, clk, rst_n, xfer && !last_res,
                    busy_r && idx_r == $past(idx_r) + rcfd_pkg::IDX_W'(1))

endmodule

`default_nettype wire

@@ hdl/rc_channel_frame_decoder_core.sv @@
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    in_rx_byte
// out       output     out_valid/out_stall  status, index, value, flags, last
// cfg       input      cfg_wr_en            cfg_index, cfg_wr_data
//
// One byte is taken per cycle unless stalled; header and payload bytes never stall.
// A good frame yields 16 results, a bad end byte yields one; the channel
// index counter sets this figure.
// The end byte of a frame stalls while the previous frame is still emitting.
// Synchronous active-low reset: hunting, header 0x0F, end value 0x00.
`default_nettype none

module rc_channel_frame_decoder_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_status,
  output logic [3:0]                          out_channel_index,
  output logic [10:0]                         out_channel_value,
  output logic                                out_digital_one,
  output logic                                out_digital_two,
  output logic                                out_lost_flag,
  output logic                                out_safe_mode_flag,
  output logic                                out_last,
  input  wire logic                           cfg_wr_en,
  input  wire logic [rcfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_wr_data
);

  logic [7:0]       header_value_r, end_value_r;
  logic             at_end;
  logic             emit_busy;
  logic             byte_take;
  rcfd_pkg::frame_t frame;

  // Config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_value_r <= rcfd_pkg::HEADER_RESET;
      end_value_r    <= rcfd_pkg::END_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rcfd_pkg::CFG_HEADER: header_value_r <= cfg_wr_data;
        rcfd_pkg::CFG_END:    end_value_r    <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Hold the end byte until the emitter is free
  assign in_stall  = at_end && emit_busy;
  assign byte_take = in_valid && !in_stall;

  rcfd_framer u_framer (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_take    (byte_take),
    .rx_byte      (in_rx_byte),
    .header_value (header_value_r),
    .end_value    (end_value_r),
    .at_end       (at_end),
    .frame        (frame)
  );

  rcfd_emitter u_emitter (
    .clk                (clk),
    .rst_n              (rst_n),
    .frame              (frame),
    .busy               (emit_busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_channel_index  (out_channel_index),
    .out_channel_value  (out_channel_value),
    .out_digital_one    (out_digital_one),
    .out_digital_two    (out_digital_two),
    .out_lost_flag      (out_lost_flag),
    .out_safe_mode_flag (out_safe_mode_flag),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire
